// ===== rtl/core/exms_pkg.sv =====
// shared types and codes for the exploration mode sequencer
package exms_pkg;

    localparam int OP_W     = 4;
    localparam int MODE_W   = 4;
    localparam int REASON_W = 5;
    localparam int CODE_W   = 8;
    localparam int TAG_W    = 16;
    localparam int REL_W    = 3;
    localparam int CNT_W    = 8;
    localparam int ERR_W    = 2;
    localparam int RR_W     = 2;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_START       = 4'd0,
        OP_WAIT        = 4'd1,
        OP_SELECT      = 4'd2,
        OP_PLAN        = 4'd3,
        OP_PAUSE       = 4'd4,
        OP_RESUME      = 4'd5,
        OP_CANCEL      = 4'd6,
        OP_COMMIT      = 4'd7,
        OP_REPLAN      = 4'd8,
        OP_RESUME_EXEC = 4'd9,
        OP_RELEASE     = 4'd10,
        OP_COMPLETE    = 4'd11,
        OP_FAIL        = 4'd12
    } op_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE   = 4'd0,
        MODE_WAIT   = 4'd1,
        MODE_SELECT = 4'd2,
        MODE_PLAN   = 4'd3,
        MODE_EXEC   = 4'd4,
        MODE_REPLAN = 4'd5,
        MODE_PAUSED = 4'd6,
        MODE_DONE   = 4'd7,
        MODE_ERROR  = 4'd8
    } mode_t;

    localparam logic [REASON_W-1:0] RSN_NONE         = 5'd0;
    localparam logic [REASON_W-1:0] RSN_STARTED      = 5'd1;
    localparam logic [REASON_W-1:0] RSN_WAITING      = 5'd2;
    localparam logic [REASON_W-1:0] RSN_SELECTING    = 5'd3;
    localparam logic [REASON_W-1:0] RSN_PLANNING     = 5'd4;
    localparam logic [REASON_W-1:0] RSN_PAUSED       = 5'd5;
    localparam logic [REASON_W-1:0] RSN_RESUMED      = 5'd6;
    localparam logic [REASON_W-1:0] RSN_CANCELED     = 5'd7;
    localparam logic [REASON_W-1:0] RSN_EXECUTING    = 5'd8;
    localparam logic [REASON_W-1:0] RSN_ROLLING      = 5'd9;
    localparam logic [REASON_W-1:0] RSN_EXHAUSTED    = 5'd10;
    localparam logic [REASON_W-1:0] RSN_STUCK_RETRY  = 5'd11;
    localparam logic [REASON_W-1:0] RSN_RELEASE_BASE = 5'd12;
    localparam logic [REASON_W-1:0] RSN_COMPLETED    = 5'd18;
    localparam logic [REASON_W-1:0] RSN_FAILED       = 5'd19;

    localparam logic [REL_W-1:0] REL_MAX = 3'd5;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE    = 2'd0,
        ERR_ILLEGAL = 2'd1,
        ERR_BAD_ARG = 2'd2
    } err_t;

    typedef enum logic [RR_W-1:0] {
        RR_NONE      = 2'd0,
        RR_STARTED   = 2'd1,
        RR_EXHAUSTED = 2'd2
    } rr_t;

    typedef struct packed {
        mode_t                mode;
        logic [REASON_W-1:0]  reason;
        logic [CODE_W-1:0]    fail_code;
        logic                 goal_held;
        logic [TAG_W-1:0]     goal_tag;
        logic [CNT_W-1:0]     retry_count;
    } seq_state_t;

    typedef struct packed {
        op_t                  op;
        logic                 task_present;
        logic [TAG_W-1:0]     goal_tag;
        logic                 goal_valid;
        logic                 replan_cause;
        logic [REL_W-1:0]     release_reason;
        logic [CODE_W-1:0]    fail_code;
    } seq_event_t;

endpackage

// ===== rtl/core/exploration_mode_sequencer_core.sv =====
// top level: input word register, event step logic, result word register
// an accepted word is held in the input register, passes the step logic
// and its result word is captured in the result word register
// throughput: one word per cycle while the result side is not stalled
// reset: mode idle, no reason, no goal, fail code zero, retry limit 3
module exploration_mode_sequencer_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [exms_pkg::CNT_W-1:0]          cfg_data,      // max_stuck_retries
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // task_present, goal_tag, goal_valid, replan_cause, release_reason, fail_code
    input  logic [exms_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  logic [exms_pkg::OP_W-1:0]           s_axis_tuser,  // op
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // error, mode, reason, last_fail_code, goal_active, active_goal_tag,
    // retries_used, replan_result, may_replace_goal
    output logic [exms_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import exms_pkg::*;

    localparam int OUT_USED_W = ERR_W + MODE_W + REASON_W + CODE_W + 1 + TAG_W + CNT_W
                                + RR_W + 1;

    logic [CNT_W-1:0] max_retries_reg;
    seq_state_t       state_reg;
    seq_state_t       state_next;
    logic             in_valid_reg;
    seq_event_t       in_event_reg;
    logic             out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;
    err_t             step_err;
    rr_t              step_rr;
    seq_event_t       s_event;
    logic             step_fire;
    logic             out_free;

    assign cfg_ready = 1'b1;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step_fire     = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        s_event.op             = op_t'(s_axis_tuser);
        s_event.task_present   = s_axis_tdata[0];
        s_event.goal_tag       = s_axis_tdata[16:1];
        s_event.goal_valid     = s_axis_tdata[17];
        s_event.replan_cause   = s_axis_tdata[18];
        s_event.release_reason = s_axis_tdata[21:19];
        s_event.fail_code      = s_axis_tdata[29:22];
    end

    exms_step u_step
    (
        .state       (state_reg),
        .ev          (in_event_reg),
        .max_retries (max_retries_reg),
        .state_next  (state_next),
        .err         (step_err),
        .rr          (step_rr)
    );

    always_comb
    begin
        out_data_next = {{(OUT_DATA_W-OUT_USED_W){1'b0}},
                         !state_next.goal_held,
                         step_rr,
                         state_next.retry_count,
                         state_next.goal_tag,
                         state_next.goal_held,
                         state_next.fail_code,
                         state_next.reason,
                         state_next.mode,
                         step_err};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_retries_reg       <= 8'd3;
            state_reg.mode        <= MODE_IDLE;
            state_reg.reason      <= RSN_NONE;
            state_reg.fail_code   <= '0;
            state_reg.goal_held   <= 1'b0;
            state_reg.goal_tag    <= '0;
            state_reg.retry_count <= '0;
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                max_retries_reg <= cfg_data;
            end
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (step_fire)
            begin
                state_reg <= state_next;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_event_reg <= s_event;
        end
        if (step_fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // a dropped goal never leaves a stale tag or retry count behind
    assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.goal_held |-> (state_reg.goal_tag == '0 && state_reg.retry_count == '0))
        else $error("goal state left over without a held goal");

    // a rejected event leaves the sequencer state untouched
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && step_err != ERR_NONE) |=> $stable(state_reg))
        else $error("rejected event changed state");

    // exhausted retries always land in selecting with no goal
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && step_rr == RR_EXHAUSTED)
            |-> (state_next.mode == MODE_SELECT && !state_next.goal_held))
        else $error("retry exhaustion did not drop the goal");

    // an empty result register never blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

// ===== rtl/core/exms_step.sv =====
// next-state logic for one event of the mode sequencer
module exms_step
(
    input  exms_pkg::seq_state_t              state,
    input  exms_pkg::seq_event_t              ev,
    input  logic [exms_pkg::CNT_W-1:0]        max_retries,
    output exms_pkg::seq_state_t              state_next,
    output exms_pkg::err_t                    err,
    output exms_pkg::rr_t                     rr
);
    import exms_pkg::*;

    seq_state_t dropped;

    always_comb
    begin
        dropped             = state;
        dropped.goal_held   = 1'b0;
        dropped.goal_tag    = '0;
        dropped.retry_count = '0;
    end

    always_comb
    begin
        state_next = state;
        err        = ERR_NONE;
        rr         = RR_NONE;
        unique case (ev.op)
            OP_START:
            begin
                if (!ev.task_present)
                begin
                    err = ERR_BAD_ARG;
                end
                else
                begin
                    state_next        = dropped;
                    state_next.mode   = MODE_WAIT;
                    state_next.reason = RSN_STARTED;
                end
            end
            OP_WAIT:
            begin
                if (state.mode != MODE_WAIT && state.mode != MODE_SELECT)
                begin
                    err = ERR_ILLEGAL;
                end
                else
                begin
                    state_next.mode   = MODE_WAIT;
                    state_next.reason = RSN_WAITING;
                end
            end
            OP_SELECT:
            begin
                if (state.mode != MODE_WAIT)
                begin
                    err = ERR_ILLEGAL;
                end
                else
                begin
                    state_next.mode   = MODE_SELECT;
                    state_next.reason = RSN_SELECTING;
                end
            end
            OP_PLAN:
            begin
                if (state.mode != MODE_SELECT)
                begin
                    err = ERR_ILLEGAL;
                end
                else
                begin
                    state_next.mode   = MODE_PLAN;
                    state_next.reason = RSN_PLANNING;
                end
            end
            OP_PAUSE:
            begin
                if (state.mode < MODE_WAIT || state.mode > MODE_REPLAN)
                begin
                    err = ERR_ILLEGAL;
                end
                else
                begin
                    state_next        = dropped;
                    state_next.mode   = MODE_PAUSED;
                    state_next.reason = RSN_PAUSED;
                end
            end
            OP_RESUME:
            begin
                if (state.mode != MODE_PAUSED)
                begin
                    err = ERR_ILLEGAL;
                end
                else
                begin
                    state_next.mode   = MODE_WAIT;
                    state_next.reason = RSN_RESUMED;
                end
            end
            OP_CANCEL:
            begin
                state_next        = dropped;
                state_next.mode   = MODE_IDLE;
                state_next.reason = RSN_CANCELED;
            end
            OP_COMMIT:
            begin
                if (state.mode != MODE_PLAN)
                begin
                    err = ERR_ILLEGAL;
                end
                else if (!ev.goal_valid)
                begin
                    err = ERR_BAD_ARG;
                end
                else
                begin
                    state_next.goal_held   = 1'b1;
                    state_next.goal_tag    = ev.goal_tag;
                    state_next.retry_count = '0;
                    state_next.mode        = MODE_EXEC;
                    state_next.reason      = RSN_EXECUTING;
                end
            end
            OP_REPLAN:
            begin
                if (state.mode != MODE_EXEC || !state.goal_held)
                begin
                    err = ERR_ILLEGAL;
                end
                else if (!ev.replan_cause)
                begin
                    state_next.mode   = MODE_REPLAN;
                    state_next.reason = RSN_ROLLING;
                    rr                = RR_STARTED;
                end
                else if (state.retry_count == max_retries)
                begin
                    // retry budget spent: give up the goal
                    state_next        = dropped;
                    state_next.mode   = MODE_SELECT;
                    state_next.reason = RSN_EXHAUSTED;
                    rr                = RR_EXHAUSTED;
                end
                else
                begin
                    state_next.retry_count = state.retry_count + 1'b1;
                    state_next.mode        = MODE_REPLAN;
                    state_next.reason      = RSN_STUCK_RETRY;
                    rr                     = RR_STARTED;
                end
            end
            OP_RESUME_EXEC:
            begin
                if (state.mode != MODE_REPLAN || !state.goal_held)
                begin
                    err = ERR_ILLEGAL;
                end
                else
                begin
                    state_next.mode   = MODE_EXEC;
                    state_next.reason = RSN_EXECUTING;
                end
            end
            OP_RELEASE:
            begin
                if ((state.mode != MODE_EXEC && state.mode != MODE_REPLAN)
                    || !state.goal_held)
                begin
                    err = ERR_ILLEGAL;
                end
                else if (ev.release_reason > REL_MAX)
                begin
                    err = ERR_BAD_ARG;
                end
                else
                begin
                    state_next        = dropped;
                    state_next.mode   = MODE_SELECT;
                    state_next.reason = RSN_RELEASE_BASE
                                        + {{(REASON_W-REL_W){1'b0}}, ev.release_reason};
                end
            end
            OP_COMPLETE:
            begin
                if (state.mode != MODE_SELECT || state.goal_held)
                begin
                    err = ERR_ILLEGAL;
                end
                else
                begin
                    state_next.mode   = MODE_DONE;
                    state_next.reason = RSN_COMPLETED;
                end
            end
            OP_FAIL:
            begin
                if (ev.fail_code == '0)
                begin
                    err = ERR_BAD_ARG;
                end
                else
                begin
                    state_next           = dropped;
                    state_next.fail_code = ev.fail_code;
                    state_next.mode      = MODE_ERROR;
                    state_next.reason    = RSN_FAILED;
                end
            end
            default:
            begin
                err = ERR_BAD_ARG;
            end
        endcase
    end

endmodule

// ===== dv/exploration_mode_sequencer_core_tb.sv =====
// self-checking testbench for the exploration mode sequencer core
module exploration_mode_sequencer_core_tb;

    import exms_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd13;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic              task_present;
        logic [TAG_W-1:0]  tag;
        logic              goal_valid;
        logic              cause;
        logic [REL_W-1:0]  rel;
        logic [CODE_W-1:0] fcode;
    } evt_t;

    typedef struct {
        err_t                err;
        mode_t               mode;
        logic [REASON_W-1:0] reason;
        logic [CODE_W-1:0]   fcode;
        logic                held;
        logic [TAG_W-1:0]    tag;
        logic [CNT_W-1:0]    retries;
        rr_t                 rr;
        logic                may_replace;
    } status_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CNT_W-1:0]      cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [OP_W-1:0]       s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    exploration_mode_sequencer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    evt_t    event_q[$];
    status_t status_q[$];
    int      errors = 0;
    int      words_out = 0;
    int      tx_idle_pct = 0;
    int      rx_idle_pct = 0;
    int      noise_pct = 0;
    int      hold_order = 0;
    int      hold_served = 0;
    int      hold_left = 0;
    int      quiet = 0;

    // predicted sequencer state
    logic [CNT_W-1:0]    retry_limit = 8'd3;
    mode_t               p_mode = MODE_IDLE;
    logic [REASON_W-1:0] p_reason = RSN_NONE;
    logic [CODE_W-1:0]   p_fcode = '0;
    logic                p_held = 1'b0;
    logic [TAG_W-1:0]    p_tag = '0;
    logic [CNT_W-1:0]    p_retries = '0;

    function automatic void drop_goal();
        p_held = 1'b0;
        p_tag = '0;
        p_retries = '0;
    endfunction

    function automatic status_t next_status(input evt_t e);
        status_t s;
        err_t    err;
        rr_t     rr;
        err = ERR_NONE;
        rr = RR_NONE;
        case (e.op)
            OP_START:
                if (!e.task_present) err = ERR_BAD_ARG;
                else
                begin
                    drop_goal();
                    p_mode = MODE_WAIT;
                    p_reason = RSN_STARTED;
                end
            OP_WAIT:
                if (p_mode != MODE_WAIT && p_mode != MODE_SELECT) err = ERR_ILLEGAL;
                else
                begin
                    p_mode = MODE_WAIT;
                    p_reason = RSN_WAITING;
                end
            OP_SELECT:
                if (p_mode != MODE_WAIT) err = ERR_ILLEGAL;
                else
                begin
                    p_mode = MODE_SELECT;
                    p_reason = RSN_SELECTING;
                end
            OP_PLAN:
                if (p_mode != MODE_SELECT) err = ERR_ILLEGAL;
                else
                begin
                    p_mode = MODE_PLAN;
                    p_reason = RSN_PLANNING;
                end
            OP_PAUSE:
                if (p_mode < MODE_WAIT || p_mode > MODE_REPLAN) err = ERR_ILLEGAL;
                else
                begin
                    drop_goal();
                    p_mode = MODE_PAUSED;
                    p_reason = RSN_PAUSED;
                end
            OP_RESUME:
                if (p_mode != MODE_PAUSED) err = ERR_ILLEGAL;
                else
                begin
                    p_mode = MODE_WAIT;
                    p_reason = RSN_RESUMED;
                end
            OP_CANCEL:
            begin
                drop_goal();
                p_mode = MODE_IDLE;
                p_reason = RSN_CANCELED;
            end
            OP_COMMIT:
                if (p_mode != MODE_PLAN) err = ERR_ILLEGAL;
                else if (!e.goal_valid) err = ERR_BAD_ARG;
                else
                begin
                    p_held = 1'b1;
                    p_tag = e.tag;
                    p_retries = '0;
                    p_mode = MODE_EXEC;
                    p_reason = RSN_EXECUTING;
                end
            OP_REPLAN:
                if (p_mode != MODE_EXEC || !p_held) err = ERR_ILLEGAL;
                else if (!e.cause)
                begin
                    p_mode = MODE_REPLAN;
                    p_reason = RSN_ROLLING;
                    rr = RR_STARTED;
                end
                else if (p_retries == retry_limit)
                begin
                    drop_goal();
                    p_mode = MODE_SELECT;
                    p_reason = RSN_EXHAUSTED;
                    rr = RR_EXHAUSTED;
                end
                else
                begin
                    // count may sit above a lowered limit and wrap around
                    p_retries = p_retries + 8'd1;
                    p_mode = MODE_REPLAN;
                    p_reason = RSN_STUCK_RETRY;
                    rr = RR_STARTED;
                end
            OP_RESUME_EXEC:
                if (p_mode != MODE_REPLAN || !p_held) err = ERR_ILLEGAL;
                else
                begin
                    p_mode = MODE_EXEC;
                    p_reason = RSN_EXECUTING;
                end
            OP_RELEASE:
                if ((p_mode != MODE_EXEC && p_mode != MODE_REPLAN) || !p_held)
                    err = ERR_ILLEGAL;
                else if (e.rel > REL_MAX) err = ERR_BAD_ARG;
                else
                begin
                    drop_goal();
                    p_mode = MODE_SELECT;
                    p_reason = RSN_RELEASE_BASE + REASON_W'(e.rel);
                end
            OP_COMPLETE:
                if (p_mode != MODE_SELECT || p_held) err = ERR_ILLEGAL;
                else
                begin
                    p_mode = MODE_DONE;
                    p_reason = RSN_COMPLETED;
                end
            OP_FAIL:
                if (e.fcode == '0) err = ERR_BAD_ARG;
                else
                begin
                    drop_goal();
                    p_fcode = e.fcode;
                    p_mode = MODE_ERROR;
                    p_reason = RSN_FAILED;
                end
            default:
                err = ERR_BAD_ARG;
        endcase
        s.err = err;
        s.mode = p_mode;
        s.reason = p_reason;
        s.fcode = p_fcode;
        s.held = p_held;
        s.tag = p_tag;
        s.retries = p_retries;
        s.rr = rr;
        s.may_replace = !p_held;
        return s;
    endfunction

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("word %0d: %s got %0h expected %0h", words_out, field, got, want);
        errors++;
    endtask

    task automatic check_field(input string field, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) report_mismatch(field, got, want);
    endtask

    // --- stimulus helpers

    function automatic evt_t any_evt(input logic [OP_W-1:0] op);
        evt_t e;
        e.op = op;
        e.task_present = 1'($urandom_range(0, 1));
        e.tag = TAG_W'($urandom);
        e.goal_valid = 1'($urandom_range(0, 1));
        e.cause = 1'($urandom_range(0, 1));
        e.rel = REL_W'($urandom_range(0, 7));
        e.fcode = CODE_W'($urandom);
        return e;
    endfunction

    function automatic void put_raw(input logic [OP_W-1:0] op, input logic tp,
                                    input logic [TAG_W-1:0] tag, input logic gv,
                                    input logic cause, input logic [REL_W-1:0] rel,
                                    input logic [CODE_W-1:0] fcode);
        evt_t e;
        e.op = op;
        e.task_present = tp;
        e.tag = tag;
        e.goal_valid = gv;
        e.cause = cause;
        e.rel = rel;
        e.fcode = fcode;
        event_q.push_back(e);
    endfunction

    // well-formed arguments, except for a few when noise is on
    function automatic void put(input logic [OP_W-1:0] op);
        evt_t e;
        if ($urandom_range(0, 99) < noise_pct)
            event_q.push_back(any_evt(OP_W'($urandom_range(0, 15))));
        e = any_evt(op);
        if (noise_pct == 0 || $urandom_range(0, 19) != 0)
        begin
            e.task_present = 1'b1;
            e.goal_valid = 1'b1;
            e.rel = REL_W'($urandom_range(0, 5));
            if (e.fcode == '0) e.fcode = 8'd1;
        end
        event_q.push_back(e);
    endfunction

    function automatic void put_stuck_replan();
        put(OP_REPLAN);
        event_q[$].cause = 1'b1;
    endfunction

    function automatic void queue_mission();
        int steps;
        put(OP_START);
        if ($urandom_range(0, 2) == 0) put(OP_WAIT);
        put(OP_SELECT);
        if ($urandom_range(0, 3) == 0)
        begin
            put(OP_WAIT);
            put(OP_SELECT);
        end
        repeat ($urandom_range(1, 3))
        begin
            put(OP_PLAN);
            put(OP_COMMIT);
            steps = $urandom_range(0, 8);
            repeat (steps)
            begin
                put(OP_REPLAN);
                event_q[$].cause = ($urandom_range(0, 9) < 7);
                if ($urandom_range(0, 9) != 0) put(OP_RESUME_EXEC);
            end
            if ($urandom_range(0, 9) == 0)
            begin
                put(OP_PAUSE);
                put(OP_RESUME);
                put(OP_SELECT);
            end
            else
                put(OP_RELEASE);
        end
        case ($urandom_range(0, 5))
            0: put(OP_FAIL);
            1: put(OP_CANCEL);
            default: put(OP_COMPLETE);
        endcase
    endfunction

    function automatic void queue_missions(input int count);
        int target;
        target = event_q.size() + count;
        while (event_q.size() < target) queue_mission();
    endfunction

    task automatic drain();
        do @(negedge clk);
        while (event_q.size() != 0 || s_axis_tvalid || status_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_limit(input logic [CNT_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk);
        while (!cfg_ready);
        retry_limit = value;
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // --- driver: one word per handshake, next word picked from the pending queue

    always @(posedge clk)
    begin : drive_events
        evt_t on_bus;
        evt_t nxt;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready) status_q.push_back(next_status(on_bus));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (event_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    nxt = event_q.pop_front();
                    on_bus = nxt;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= nxt.op;
                    s_axis_tdata <= {2'b00, nxt.fcode, nxt.rel, nxt.cause, nxt.goal_valid,
                                     nxt.tag, nxt.task_present};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // --- monitor: compare each result word with the oldest predicted status

    always @(posedge clk)
    begin : watch_status
        status_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (status_q.size() == 0)
                    report_mismatch("unexpected word", m_axis_tdata[15:0], '0);
                else
                begin
                    want = status_q.pop_front();
                    check_field("error", 16'(m_axis_tdata[1:0]), 16'(want.err));
                    check_field("mode", 16'(m_axis_tdata[5:2]), 16'(want.mode));
                    check_field("reason", 16'(m_axis_tdata[10:6]), 16'(want.reason));
                    check_field("last_fail_code", 16'(m_axis_tdata[18:11]),
                                16'(want.fcode));
                    check_field("goal_active", 16'(m_axis_tdata[19]), 16'(want.held));
                    check_field("active_goal_tag", m_axis_tdata[35:20], want.tag);
                    check_field("retries_used", 16'(m_axis_tdata[43:36]),
                                16'(want.retries));
                    check_field("replan_result", 16'(m_axis_tdata[45:44]), 16'(want.rr));
                    check_field("may_replace_goal", 16'(m_axis_tdata[46]),
                                16'(want.may_replace));
                end
                words_out++;
            end
            if (hold_served != hold_order)
            begin
                hold_left = HOLD_CYCLES;
                hold_served = hold_order;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
            begin
                quiet++;
                if (quiet >= STALL_LIMIT)
                begin
                    $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
                    $display("exploration_mode_sequencer_core_tb: done, errors");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset limit of 3
        tx_idle_pct = 17;
        rx_idle_pct = 58;
        put_raw(OP_COMPLETE, 1'b1, '0, 1'b1, 1'b0, 3'd0, 8'd1);
        put_raw(OP_UNUSED_HI, 1'b1, 16'hffff, 1'b1, 1'b1, 3'd7, 8'hff);
        put_raw(OP_UNUSED_LO, 1'b0, '0, 1'b0, 1'b0, 3'd0, '0);
        put_raw(OP_START, 1'b0, 16'hffff, 1'b1, 1'b1, 3'd7, 8'hff);
        put_raw(OP_FAIL, 1'b1, '0, 1'b0, 1'b0, 3'd0, '0);
        put_raw(OP_RELEASE, 1'b1, '0, 1'b1, 1'b0, 3'd7, 8'd1);
        put_raw(OP_START, 1'b1, '0, 1'b0, 1'b0, 3'd0, 8'd1);
        put_raw(OP_WAIT, 1'b1, '0, 1'b0, 1'b0, 3'd0, 8'd1);
        put_raw(OP_SELECT, 1'b1, '0, 1'b0, 1'b0, 3'd0, 8'd1);
        put_raw(OP_PLAN, 1'b1, '0, 1'b0, 1'b0, 3'd0, 8'd1);
        put_raw(OP_COMMIT, 1'b1, 16'hffff, 1'b0, 1'b0, 3'd0, 8'd1);
        put_raw(OP_COMMIT, 1'b1, 16'hffff, 1'b1, 1'b0, 3'd0, 8'd1);
        put_raw(OP_REPLAN, 1'b1, '0, 1'b1, 1'b0, 3'd0, 8'd1);
        put_raw(OP_RESUME_EXEC, 1'b1, '0, 1'b1, 1'b0, 3'd0, 8'd1);
        put_raw(OP_RELEASE, 1'b1, '0, 1'b1, 1'b0, 3'd6, 8'd1);
        // three stuck retries, then the fourth drops the goal
        repeat (4)
        begin
            put_raw(OP_REPLAN, 1'b1, '0, 1'b1, 1'b1, 3'd0, 8'd1);
            put_raw(OP_RESUME_EXEC, 1'b1, '0, 1'b1, 1'b0, 3'd0, 8'd1);
        end
        put_raw(OP_COMPLETE, 1'b1, '0, 1'b1, 1'b0, 3'd0, 8'd1);
        put_raw(OP_FAIL, 1'b1, '0, 1'b1, 1'b0, 3'd0, 8'hff);
        put_raw(OP_PAUSE, 1'b1, '0, 1'b1, 1'b0, 3'd0, 8'd1);
        put_raw(OP_CANCEL, 1'b1, '0, 1'b1, 1'b0, 3'd0, 8'd1);
        put_raw(OP_RESUME, 1'b1, '0, 1'b1, 1'b0, 3'd0, 8'd1);
        drain();

        // zero retries allowed; receiver stalls long while words keep coming
        write_limit(8'd0);
        noise_pct = 8;
        hold_order++;
        queue_missions(500);
        drain();

        // one goal piles up retries under the widest limit
        write_limit(8'd255);
        tx_idle_pct = 58;
        rx_idle_pct = 17;
        noise_pct = 0;
        put(OP_START);
        put(OP_SELECT);
        put(OP_PLAN);
        put(OP_COMMIT);
        repeat (200)
        begin
            put_stuck_replan();
            put(OP_RESUME_EXEC);
        end
        drain();

        // limit drops below the held count: count wraps before it exhausts
        write_limit(8'd10);
        repeat (70)
        begin
            put_stuck_replan();
            put(OP_RESUME_EXEC);
        end
        noise_pct = 8;
        queue_missions(300);
        drain();

        write_limit(CNT_W'($urandom_range(1, 8)));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        queue_missions(200);
        drain();

        write_limit(8'd1);
        queue_missions(200);
        drain();

        if (errors == 0)
            $display("exploration_mode_sequencer_core_tb: done, clean");
        else
            $display("exploration_mode_sequencer_core_tb: done, errors");
        $finish;
    end

endmodule
